### design/tps_pkg.sv
// Package for the trapezoidal pulse shaper.
// Field widths, register indexes, reset values and the control state type.
`timescale 1ns / 1ps

package tps_pkg;

  localparam int SAMPLE_W   = 14;
  localparam int CFG_W      = 7;
  localparam int CFG_ADDR_W = 1;
  localparam int OUT_W      = 30;
  localparam int FRAC_W     = 8;
  localparam int IDX_W      = 8;

  localparam logic [IDX_W-1:0]      IDX_MAX = 8'd255;
  localparam logic [CFG_W-1:0]      RISE_RST = 7'd3;
  localparam logic [CFG_W-1:0]      TOP_RST  = 7'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RISE_LEN     = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FLAT_TOP_LEN = 1'd1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_ABS  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

endpackage

### design/trapezoidal_pulse_shaper.sv
// Trapezoidal pulse shaper, top level.
// Depends on tps_pkg and tps_div.
`timescale 1ns / 1ps

// Usage:
//  s_axis carries one ADC sample per item, tuser flags the first sample of a
//  trace. m_axis returns one result per item: tdata is the signed value with
//  8 fractional bits, tuser is 1 when the value is filtered, 0 on pass-through.
//  cfg_we_i/cfg_addr_i/cfg_wdata_i write rise_len (index 0) and flat_top_len
//  (index 1); write only while the block is idle.
//  Timing: a pass-through item goes from idle to the finish state, which moves
//  it into the output register. A filtered item issues rise_len+1 reads on
//  the two registered history read ports, rise_len being the clamped value,
//  latches the sign in the abs state, then runs the bit-serial divider (one
//  quotient bit per cycle); the finish state moves its result into the output
//  register. One item at a time.
//  The next item is taken while a finished result waits in the output
//  register; a stalled receiver holds the block once a second result is ready.
//  Reset clears control, the sample counter and the write pointer and loads
//  the register defaults (3 and 3). The history is not cleared: the sample
//  counter only lets the filter read samples written since reset.
module trapezoidal_pulse_shaper
  import tps_pkg::*;
#(
  parameter int MAX_RISE = 64,
  parameter int MAX_TOP  = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // [13:0] sample
  input  logic                  s_axis_tuser,   // [0] trace_start
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,   // [29:0] filtered_value
  output logic                  m_axis_tuser,   // [0] shaped
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  localparam int DEPTH = MAX_RISE + MAX_TOP + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_RISE + 1);
  localparam int TW    = (MAX_TOP > 0) ? $clog2(MAX_TOP + 1) : 1;
  localparam int MW    = $clog2((MAX_RISE + 1) * (2 ** SAMPLE_W - 1) + 1);
  localparam int SW    = MW + 1;
  localparam int DW    = MW + FRAC_W;

  state_e state_q, state_d;

  logic [CFG_W-1:0]    cfg_rise_q, cfg_top_q;
  logic [RW-1:0]       rise_eff, rise_q;
  logic [TW-1:0]       top_eff;
  logic [IDX_W-1:0]    idx_q, pos;
  logic [AW-1:0]       wp_q, wp_new, lag_start;
  logic [SAMPLE_W-1:0] hist_mem [DEPTH];
  logic [SAMPLE_W-1:0] lead_rd_q, lag_rd_q;
  logic [AW-1:0]       lead_ptr_q, lag_ptr_q;
  logic [RW-1:0]       iss_cnt_q;
  logic                iss_done_q, rd_vld_q, rd_last_q, issue;
  logic signed [SW-1:0] acc_q;
  logic                neg_q;
  logic [MW-1:0]       mag;
  logic [OUT_W-1:0]    res_q;
  logic                res_shaped_q;
  logic [OUT_W-1:0]    out_data_q;
  logic                out_shaped_q, out_vld_q;
  logic                in_acc, shaped, out_free;
  logic                div_done;
  logic [DW-1:0]       div_quot;

  // Effective register values after clamping
  always_comb begin
    if (cfg_rise_q == '0) begin
      rise_eff = RW'(1);
    end else if (32'(cfg_rise_q) > MAX_RISE) begin
      rise_eff = RW'(MAX_RISE);
    end else begin
      rise_eff = RW'(cfg_rise_q);
    end
    if (32'(cfg_top_q) > MAX_TOP) begin
      top_eff = TW'(MAX_TOP);
    end else begin
      top_eff = TW'(cfg_top_q);
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pos           = s_axis_tuser ? '0 : idx_q;
  assign shaped        = 32'(pos) >= (32'(rise_eff) + 32'(top_eff));
  assign wp_new        = (32'(wp_q) == DEPTH - 1) ? '0 : wp_q + 1'b1;
  assign lag_start     = (32'(wp_new) >= 32'(top_eff)) ?
                         AW'(32'(wp_new) - 32'(top_eff)) :
                         AW'(32'(wp_new) + DEPTH - 32'(top_eff));
  assign issue         = (state_q == ST_SUM) && !iss_done_q;
  assign mag           = acc_q[SW-1] ? MW'(-acc_q) : MW'(acc_q);
  assign out_free      = !out_vld_q || m_axis_tready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_rise_q <= RISE_RST;
      cfg_top_q  <= TOP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_RISE_LEN:     cfg_rise_q <= cfg_wdata_i;
        REG_FLAT_TOP_LEN: cfg_top_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sample history, one write port and two registered read ports
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hist_mem[wp_new] <= s_axis_tdata[SAMPLE_W-1:0];
    end
    lead_rd_q <= hist_mem[lead_ptr_q];
    lag_rd_q  <= hist_mem[lag_ptr_q];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = shaped ? ST_SUM : ST_FIN;
      ST_SUM:  if (rd_vld_q && rd_last_q) state_d = ST_ABS;
      ST_ABS:  state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      wp_q       <= '0;
      iss_done_q <= 1'b1;
      rd_vld_q   <= 1'b0;
      rd_last_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= issue;
      rd_last_q <= issue && (iss_cnt_q == '0);
      if (in_acc) begin
        idx_q      <= (pos < IDX_MAX) ? pos + 1'b1 : pos;
        wp_q       <= wp_new;
        iss_done_q <= 1'b0;
      end else if (issue && (iss_cnt_q == '0)) begin
        iss_done_q <= 1'b1;
      end
      if (state_q == ST_FIN && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lead_ptr_q   <= wp_new;
      lag_ptr_q    <= lag_start;
      iss_cnt_q    <= rise_eff;
      rise_q       <= rise_eff;
      acc_q        <= '0;
      res_q        <= OUT_W'({s_axis_tdata[SAMPLE_W-1:0], {FRAC_W{1'b0}}});
      res_shaped_q <= 1'b0;
    end
    if (issue) begin
      lead_ptr_q <= (lead_ptr_q == '0) ? AW'(DEPTH - 1) : lead_ptr_q - 1'b1;
      lag_ptr_q  <= (lag_ptr_q == '0) ? AW'(DEPTH - 1) : lag_ptr_q - 1'b1;
      iss_cnt_q  <= iss_cnt_q - 1'b1;
    end
    if (rd_vld_q) begin
      acc_q <= acc_q + $signed({{(SW - SAMPLE_W){1'b0}}, lead_rd_q})
                     - $signed({{(SW - SAMPLE_W){1'b0}}, lag_rd_q});
    end
    if (state_q == ST_ABS) begin
      neg_q <= acc_q[SW-1];
    end
    if (state_q == ST_DIV && div_done) begin
      res_q        <= neg_q ? OUT_W'(-OUT_W'(div_quot)) : OUT_W'(div_quot);
      res_shaped_q <= 1'b1;
    end
    if (state_q == ST_FIN && out_free) begin
      out_data_q   <= res_q;
      out_shaped_q <= res_shaped_q;
    end
  end

  tps_div #(
    .DW (DW),
    .RW (RW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_ABS),
    .dividend_i ({mag, {FRAC_W{1'b0}}}),
    .divisor_i  (rise_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(32 - OUT_W){1'b0}}, out_data_q};
  assign m_axis_tuser  = out_shaped_q;

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_rd_in_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> state_q == ST_SUM)
    else $error("history read returned outside the sum state");

  a_pass_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !shaped |=> state_q == ST_FIN)
    else $error("pass-through item did not go straight to finish");

  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(wp_q) <= DEPTH - 1)
    else $error("history write pointer out of range");

endmodule

### design/tps_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Used by the trapezoidal pulse shaper; no package dependency.
`timescale 1ns / 1ps

module tps_div #(
  parameter int DW = 29,
  parameter int RW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [RW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q, quo_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [RW-1:0] dvs_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [RW:0]   rem_sh;
  logic          ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[DW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DW-2:0], ge};
      rem_d = ge ? RW'(rem_sh - {1'b0, dvs_q}) : RW'(rem_sh);
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
